@@ hdl/brs_pkg.sv @@
// Shared constants for the bilinear RGBA sampler: field widths, command codes,
// register indexes and parameter defaults. No dependencies.
`default_nettype none

package brs_pkg;

    // Parameter defaults
    localparam int MAX_COLS_DEF     = 64;
    localparam int MAX_ROWS_DEF     = 64;
    localparam int CHANNEL_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 8;

    // Fixed field widths
    localparam int WIN_BITS  = 12;   // window registers
    localparam int POS_BITS  = 20;   // sample position
    localparam int LOAD_BITS = 6;    // load column / row offset
    localparam int NUM_CH    = 4;    // RGBA
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    // Command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_MIN_COL = 2'd0;
    localparam logic [1:0] REG_MAX_COL = 2'd1;
    localparam logic [1:0] REG_MIN_ROW = 2'd2;
    localparam logic [1:0] REG_MAX_ROW = 2'd3;

    // Register reset values
    localparam logic [WIN_BITS-1:0] RST_MIN_COL = 12'd0;
    localparam logic [WIN_BITS-1:0] RST_MAX_COL = 12'd63;
    localparam logic [WIN_BITS-1:0] RST_MIN_ROW = 12'd0;
    localparam logic [WIN_BITS-1:0] RST_MAX_ROW = 12'd63;

endpackage

`default_nettype wire

@@ hdl/brs_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module brs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/bilinear_rgba_sampler.sv @@
// Bilinear RGBA sampler, top level: command channel, APB window registers,
// clamp/weight logic, read sequencer and per-channel MAC lanes.
// Depends on brs_pkg and brs_ram.
`default_nettype none

// Holds a MAX_ROWS x MAX_COLS image of RGBA pixels (CHANNEL_BITS signed per
// channel) in one single-port RAM. A load beat (command 0) writes one pixel
// into the store; offsets outside the store are dropped. A sample beat
// (command 1) takes a signed position with FRAC_BITS fraction bits, floors
// it, clamps both neighbour columns and rows to the window registers
// (saturating into the store), reads the four pixels one per cycle and
// blends each channel with weights (2^F - f, f), rounding to nearest with
// ties up. A sample's result is registered after four RAM reads through the
// single port and a final accumulate; the next beat is taken only once that
// result has gone into the output register. A result may sit in the output
// register while the next beat is accepted; the sequencer waits only if a
// second result is ready before the first is taken. After reset the RAM is
// zeroed by a clearing pass over all MAX_COLS*MAX_ROWS addresses, during
// which o_in_ready is low;
// register writes are taken at any time. Registers sit at byte addresses
// 0, 4, 8, 12: min column, max column, min row, max row (12-bit signed).
// Write them only while the block is idle.
module bilinear_rgba_sampler #(
    parameter int MAX_COLS     = brs_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS     = brs_pkg::MAX_ROWS_DEF,
    parameter int CHANNEL_BITS = brs_pkg::CHANNEL_BITS_DEF,
    parameter int FRAC_BITS    = brs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // command channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic                                  i_command,
    input  wire logic        [brs_pkg::LOAD_BITS-1:0]  i_load_col,
    input  wire logic        [brs_pkg::LOAD_BITS-1:0]  i_load_row,
    input  wire logic signed [CHANNEL_BITS-1:0]        i_load_red,
    input  wire logic signed [CHANNEL_BITS-1:0]        i_load_green,
    input  wire logic signed [CHANNEL_BITS-1:0]        i_load_blue,
    input  wire logic signed [CHANNEL_BITS-1:0]        i_load_alpha,
    input  wire logic signed [brs_pkg::POS_BITS-1:0]   i_sample_x,
    input  wire logic signed [brs_pkg::POS_BITS-1:0]   i_sample_y,
    // result channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed [CHANNEL_BITS-1:0]             o_out_red,
    output logic signed [CHANNEL_BITS-1:0]             o_out_green,
    output logic signed [CHANNEL_BITS-1:0]             o_out_blue,
    output logic signed [CHANNEL_BITS-1:0]             o_out_alpha,
    // APB register port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic        [brs_pkg::APB_AW-1:0]     paddr,
    input  wire logic        [brs_pkg::APB_DW-1:0]     pwdata,
    output logic             [brs_pkg::APB_DW-1:0]     prdata,
    output logic                                       pready
);

    localparam int NCH   = brs_pkg::NUM_CH;
    localparam int CB    = CHANNEL_BITS;
    localparam int F     = FRAC_BITS;
    localparam int WB    = brs_pkg::WIN_BITS;
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int IW    = brs_pkg::POS_BITS - F;          // integer part
    localparam int EW    = ((IW > WB) ? IW : WB) + 2;      // clamp arithmetic
    localparam int WW    = 2 * F + 1;                      // weight
    localparam int AC    = CB + 2 * F + 2;                 // accumulator
    localparam int ONE   = 1 << F;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_HOLD
    } t_state;

    // ---------------------------------------------------------------
    // Window registers (APB)
    // ---------------------------------------------------------------
    logic [WB-1:0] r_min_col, r_max_col, r_min_row, r_max_row;
    logic          cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_col <= brs_pkg::RST_MIN_COL;
            r_max_col <= brs_pkg::RST_MAX_COL;
            r_min_row <= brs_pkg::RST_MIN_ROW;
            r_max_row <= brs_pkg::RST_MAX_ROW;
        end else if (cfg_we) begin
            case (paddr[3:2])
                brs_pkg::REG_MIN_COL: r_min_col <= pwdata[WB-1:0];
                brs_pkg::REG_MAX_COL: r_max_col <= pwdata[WB-1:0];
                brs_pkg::REG_MIN_ROW: r_min_row <= pwdata[WB-1:0];
                brs_pkg::REG_MAX_ROW: r_max_row <= pwdata[WB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            brs_pkg::REG_MIN_COL: prdata[WB-1:0] = r_min_col;
            brs_pkg::REG_MAX_COL: prdata[WB-1:0] = r_max_col;
            brs_pkg::REG_MIN_ROW: prdata[WB-1:0] = r_min_row;
            brs_pkg::REG_MAX_ROW: prdata[WB-1:0] = r_max_row;
            default: prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Clamp-to-edge: clamp into [lo, hi] (lo wins on inverted window),
    // then offset from lo saturated into [0, dim-1].
    // ---------------------------------------------------------------
    function automatic logic [EW-1:0] edge_off(
        input logic signed [EW-1:0] c,
        input logic signed [EW-1:0] lo,
        input logic signed [EW-1:0] hi,
        input int                   dim
    );
        logic signed [EW-1:0] v;
        logic signed [EW-1:0] off;
        v = c;
        if (c < lo) begin
            v = lo;
        end else if (c > hi) begin
            v = hi;
        end
        off = v - lo;
        if (off < $signed(EW'(0))) begin
            off = '0;
        end else if (off > $signed(EW'(dim - 1))) begin
            off = EW'(dim - 1);
        end
        return off;
    endfunction

    logic signed [IW-1:0] xi, yi;
    logic signed [EW-1:0] xe, ye;
    logic        [F-1:0]  xf, yf;
    logic        [F:0]    wx0, wx1, wy0, wy1;
    logic        [EW-1:0] off_c1, off_c2, off_r1, off_r2;

    assign xi  = i_sample_x[brs_pkg::POS_BITS-1:F];
    assign yi  = i_sample_y[brs_pkg::POS_BITS-1:F];
    assign xf  = i_sample_x[F-1:0];
    assign yf  = i_sample_y[F-1:0];
    assign xe  = EW'(xi);
    assign ye  = EW'(yi);
    assign wx1 = {1'b0, xf};
    assign wy1 = {1'b0, yf};
    assign wx0 = (F+1)'(ONE) - wx1;
    assign wy0 = (F+1)'(ONE) - wy1;

    assign off_c1 = edge_off(xe, EW'($signed(r_min_col)), EW'($signed(r_max_col)), MAX_COLS);
    assign off_c2 = edge_off(xe + EW'(1), EW'($signed(r_min_col)),
                             EW'($signed(r_max_col)), MAX_COLS);
    assign off_r1 = edge_off(ye, EW'($signed(r_min_row)), EW'($signed(r_max_row)), MAX_ROWS);
    assign off_r2 = edge_off(ye + EW'(1), EW'($signed(r_min_row)),
                             EW'($signed(r_max_row)), MAX_ROWS);

    // ---------------------------------------------------------------
    // Sequencer control
    // ---------------------------------------------------------------
    t_state        r_state;
    logic [1:0]    r_rd_k;       // neighbour being read
    logic          r_dv;         // RAM data valid this cycle
    logic [1:0]    r_dk;         // neighbour of the returning data
    logic [AW-1:0] r_clr_addr;
    logic          r_out_valid;
    logic signed [CB-1:0] r_out [NCH];

    logic in_acc, is_load, is_sample, load_ok, out_free, out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    assign is_load    = in_acc & (i_command == brs_pkg::CMD_LOAD);
    assign is_sample  = in_acc & (i_command == brs_pkg::CMD_SAMPLE);
    assign load_ok    = (int'(i_load_col) < MAX_COLS) && (int'(i_load_row) < MAX_ROWS);
    assign out_free   = !r_out_valid || i_out_ready;
    assign out_load   = ((r_state == S_DRAIN) || (r_state == S_HOLD)) && out_free;

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    logic [CW-1:0]        r_c1, r_c2;
    logic [RW-1:0]        r_r1, r_r2;
    logic [WW-1:0]        r_w [NCH];
    logic signed [AC-1:0] r_acc [NCH];

    logic signed [CB-1:0]   pix      [NCH];
    logic signed [AC-1:0]   prod     [NCH];
    logic signed [AC-1:0]   acc_next [NCH];
    logic [WW-1:0]          w_sel;
    logic [CW-1:0]          rd_col;
    logic [RW-1:0]          rd_row;
    logic [AW-1:0]          rd_addr, ld_addr, ram_addr;
    logic                   ram_we;
    logic [NCH*CB-1:0]      ram_wdata, ram_rdata;

    assign w_sel  = r_w[r_dk];
    assign rd_col = r_rd_k[0] ? r_c2 : r_c1;
    assign rd_row = r_rd_k[1] ? r_r2 : r_r1;
    assign rd_addr = AW'(rd_row) * AW'(MAX_COLS) + AW'(rd_col);
    assign ld_addr = AW'(i_load_row) * AW'(MAX_COLS) + AW'(i_load_col);

    // one MAC per channel lane
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            pix[ch]      = ram_rdata[ch*CB +: CB];
            prod[ch]     = AC'(pix[ch] * $signed({1'b0, w_sel}));
            acc_next[ch] = r_dv ? r_acc[ch] + prod[ch] : r_acc[ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_sample) begin
            r_c1 <= off_c1[CW-1:0];
            r_c2 <= off_c2[CW-1:0];
            r_r1 <= off_r1[RW-1:0];
            r_r2 <= off_r2[RW-1:0];
            r_w[0] <= WW'(wx0) * WW'(wy0);
            r_w[1] <= WW'(wx1) * WW'(wy0);
            r_w[2] <= WW'(wx0) * WW'(wy1);
            r_w[3] <= WW'(wx1) * WW'(wy1);
            for (int ch = 0; ch < NCH; ch++) begin
                r_acc[ch] <= AC'(1) <<< (2 * F - 1);   // rounding bias
            end
        end else begin
            for (int ch = 0; ch < NCH; ch++) begin
                r_acc[ch] <= acc_next[ch];
            end
        end
    end

    // ---------------------------------------------------------------
    // RAM port: clear sweep, pixel load, or neighbour read
    // ---------------------------------------------------------------
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = rd_addr;
        ram_wdata = {i_load_alpha, i_load_blue, i_load_green, i_load_red};
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_addr  = r_clr_addr;
            ram_wdata = '0;
        end else if (is_load) begin
            ram_we   = load_ok;
            ram_addr = ld_addr;
        end
    end

    brs_ram #(
        .WIDTH (NCH * CB),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // State machine and output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rd_k      <= '0;
            r_dv        <= 1'b0;
            r_dk        <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_dv <= 1'b0;
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (is_sample) begin
                        r_rd_k  <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_dv   <= 1'b1;
                    r_dk   <= r_rd_k;
                    r_rd_k <= r_rd_k + 2'd1;
                    if (r_rd_k == 2'd3) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN, S_HOLD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        for (int ch = 0; ch < NCH; ch++) begin
                            r_out[ch] <= acc_next[ch][2*F +: CB];
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_HOLD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out[0];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[2];
    assign o_out_alpha = r_out[3];

`ifndef NO_ASSERTIONS
    // no command beat taken while the store is being zeroed
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("command accepted during clearing pass");

    // RAM writes never collide with a neighbour read
    a_write_not_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_CLEAR) || (r_state == S_IDLE)))
        else $error("RAM write during sample read");

    // returning read data only while a sample is being blended
    a_data_in_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> ((r_state == S_READ) || (r_state == S_DRAIN)))
        else $error("stray RAM read data");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // the last neighbour is accumulated in the drain cycle
    a_drain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_dv && (r_dk == 2'd3)))
        else $error("drain without last neighbour");
`endif

endmodule

`default_nettype wire

@@ tb/brs_checker.sv @@
// Scoreboard for the bilinear RGBA sampler: mirrors the pixel store and the
// window registers, predicts every sample result and checks the result channel.
// Depends on brs_pkg.
module brs_checker
    import brs_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_command,
    input  logic [LOAD_BITS-1:0]         i_load_col,
    input  logic [LOAD_BITS-1:0]         i_load_row,
    input  logic [CHANNEL_BITS_DEF-1:0]  i_load_red,
    input  logic [CHANNEL_BITS_DEF-1:0]  i_load_green,
    input  logic [CHANNEL_BITS_DEF-1:0]  i_load_blue,
    input  logic [CHANNEL_BITS_DEF-1:0]  i_load_alpha,
    input  logic [POS_BITS-1:0]          i_sample_x,
    input  logic [POS_BITS-1:0]          i_sample_y,
    // result channel
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [CHANNEL_BITS_DEF-1:0]  i_out_red,
    input  logic [CHANNEL_BITS_DEF-1:0]  i_out_green,
    input  logic [CHANNEL_BITS_DEF-1:0]  i_out_blue,
    input  logic [CHANNEL_BITS_DEF-1:0]  i_out_alpha,
    // register port
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [APB_AW-1:0]            i_paddr,
    input  logic [APB_DW-1:0]            i_pwdata,
    input  logic                         i_pready,
    // status
    output int                           o_pending,
    output int                           o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS = MAX_COLS_DEF;
    localparam int ROWS = MAX_ROWS_DEF;
    localparam int CH   = CHANNEL_BITS_DEF;
    localparam int FRAC = FRAC_BITS_DEF;
    localparam int ONE  = 1 << FRAC;

    // channel 0 = red ... 3 = alpha
    typedef logic [NUM_CH-1:0][CH-1:0] rgba_t;

    rgba_t                      pixel_mem [COLS*ROWS];
    logic signed [WIN_BITS-1:0] win_min_col, win_max_col, win_min_row, win_max_row;
    rgba_t                      blend_q [$];
    string                      ch_name [NUM_CH] = '{"red", "green", "blue", "alpha"};

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    // clamp to the window, then saturate the offset into the store
    function automatic int edge_offset(int c, int lo, int hi, int dim);
        int off;
        if (c < lo) begin
            c = lo;
        end else if (c > hi) begin
            c = hi;
        end
        off = c - lo;
        if (off < 0) off = 0;
        if (off > dim - 1) off = dim - 1;
        return off;
    endfunction

    function automatic rgba_t blend_sample(logic [POS_BITS-1:0] px, logic [POS_BITS-1:0] py);
        int          xi, yi, c_lo, c_hi, r_lo, r_hi;
        int          at [4];
        int unsigned xf, yf;
        longint      wt [4];
        longint      acc, q;
        rgba_t       res;
        xi = $signed(px);
        yi = $signed(py);
        xi = xi >>> FRAC;    // floor
        yi = yi >>> FRAC;
        xf = px[FRAC-1:0];
        yf = py[FRAC-1:0];
        c_lo = edge_offset(xi,     win_min_col, win_max_col, COLS);
        c_hi = edge_offset(xi + 1, win_min_col, win_max_col, COLS);
        r_lo = edge_offset(yi,     win_min_row, win_max_row, ROWS);
        r_hi = edge_offset(yi + 1, win_min_row, win_max_row, ROWS);
        at[0] = r_lo * COLS + c_lo;
        at[1] = r_lo * COLS + c_hi;
        at[2] = r_hi * COLS + c_lo;
        at[3] = r_hi * COLS + c_hi;
        wt[0] = (ONE - xf) * (ONE - yf);
        wt[1] = xf * (ONE - yf);
        wt[2] = (ONE - xf) * yf;
        wt[3] = xf * yf;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            acc = longint'(1) << (2*FRAC - 1);   // round half up
            for (int k = 0; k < 4; k++)
                acc += longint'($signed(pixel_mem[at[k]][ch])) * wt[k];
            q = acc >>> (2*FRAC);
            res[ch] = q[CH-1:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        rgba_t want, got;
        if (!i_rst_n) begin
            foreach (pixel_mem[a]) pixel_mem[a] = '0;
            win_min_col = RST_MIN_COL;
            win_max_col = RST_MAX_COL;
            win_min_row = RST_MIN_ROW;
            win_max_row = RST_MAX_ROW;
            blend_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (i_command == CMD_SAMPLE) begin
                    blend_q.push_back(blend_sample(i_sample_x, i_sample_y));
                end else if (int'(i_load_col) < COLS && int'(i_load_row) < ROWS) begin
                    pixel_mem[int'(i_load_row) * COLS + int'(i_load_col)] =
                        {i_load_alpha, i_load_blue, i_load_green, i_load_red};
                end
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_out_alpha, i_out_blue, i_out_green, i_out_red};
                if (blend_q.size() == 0) begin
                    $display("%0t: unexpected result, none expected, got %h", $time, got);
                    o_fail_count++;
                end else begin
                    want = blend_q.pop_front();
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        if (want[ch] !== got[ch]) begin
                            $display("%0t: %s mismatch: expected %0d, got %0d", $time,
                                     ch_name[ch], $signed(want[ch]), $signed(got[ch]));
                            o_fail_count++;
                        end
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_MIN_COL: win_min_col = i_pwdata[WIN_BITS-1:0];
                    REG_MAX_COL: win_max_col = i_pwdata[WIN_BITS-1:0];
                    REG_MIN_ROW: win_min_row = i_pwdata[WIN_BITS-1:0];
                    REG_MAX_ROW: win_max_row = i_pwdata[WIN_BITS-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = blend_q.size();
    end

endmodule

@@ tb/tb_bilinear_rgba_sampler.sv @@
// Top of the bilinear RGBA sampler testbench: clock, reset, beat and register
// stimulus, receiver back-pressure, watchdog and verdict.
// Depends on brs_pkg, bilinear_rgba_sampler and brs_checker.
module tb_bilinear_rgba_sampler;
    timeunit 1ns;
    timeprecision 1ps;
    import brs_pkg::*;

    localparam int CH          = CHANNEL_BITS_DEF;
    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int PHASES      = 8;
    localparam int BEATS_PER   = 100;     // random beats per phase
    localparam int PRESS_BEATS = 30;
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off
    localparam int DRAIN_WAIT  = 24;      // load leaves no result
    localparam int QUIET_LIMIT = 20000;   // covers the clearing pass over all 4096 addresses

    // One command beat, all fields carried whatever the command.
    typedef struct packed {
        logic                command;
        logic [LOAD_BITS-1:0] col;
        logic [LOAD_BITS-1:0] row;
        logic [CH-1:0]       red;
        logic [CH-1:0]       green;
        logic [CH-1:0]       blue;
        logic [CH-1:0]       alpha;
        logic [POS_BITS-1:0] x;
        logic [POS_BITS-1:0] y;
    } beat_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_command;
    logic [LOAD_BITS-1:0] i_load_col, i_load_row;
    logic [CH-1:0]        i_load_red, i_load_green, i_load_blue, i_load_alpha;
    logic [POS_BITS-1:0]  i_sample_x, i_sample_y;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [CH-1:0]        o_out_red, o_out_green, o_out_blue, o_out_alpha;
    logic                 psel, penable, pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int   pending, fail_count;
    int   send_idle_pct, recv_stall_pct;
    logic hold_req;
    int   cur_win [4];                    // window as last written, shapes positions only

    // Window settings per phase: plain store-sized window, full-range window wider
    // than the store, inverted window, inverted extremes, offset window, single
    // column at the bottom-most row, window near the top of the range, and a
    // random one (filled in at run time).
    int phase_win [PHASES][4] = '{
        '{0, 63, 0, 63},
        '{-2048, 2047, -2048, 2047},
        '{10, 5, 40, 20},
        '{2047, -2048, 2047, -2048},
        '{-5, 30, 3, 70},
        '{7, 7, -2048, -2048},
        '{2000, 2047, -40, -1},
        '{0, 0, 0, 0}
    };

    bilinear_rgba_sampler u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_load_col   (i_load_col),
        .i_load_row   (i_load_row),
        .i_load_red   (i_load_red),
        .i_load_green (i_load_green),
        .i_load_blue  (i_load_blue),
        .i_load_alpha (i_load_alpha),
        .i_sample_x   (i_sample_x),
        .i_sample_y   (i_sample_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .o_out_alpha  (o_out_alpha),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    brs_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_load_col   (i_load_col),
        .i_load_row   (i_load_row),
        .i_load_red   (i_load_red),
        .i_load_green (i_load_green),
        .i_load_blue  (i_load_blue),
        .i_load_alpha (i_load_alpha),
        .i_sample_x   (i_sample_x),
        .i_sample_y   (i_sample_y),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_red    (o_out_red),
        .i_out_green  (o_out_green),
        .i_out_blue   (o_out_blue),
        .i_out_alpha  (o_out_alpha),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // Channel level: mostly random, with the range ends, zero and -1 often.
    function automatic logic [CH-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return CH'($urandom);
        endcase
    endfunction

    // Sample coordinate for a window lo..hi. Nearly half land just around the low
    // edge (where loads are concentrated), some spread over the part of the
    // window that maps into the store, the rest are raw 20-bit noise.
    function automatic logic [POS_BITS-1:0] pick_pos(int lo, int hi);
        int a, b, ip, fr, r;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        r = $urandom_range(0, 99);
        if (r < 15) return POS_BITS'($urandom);
        if (r < 60) ip = a - 2 + int'($urandom_range(0, 11));
        else        ip = a - 3 + int'($urandom_range(0, ((b - a) < 66 ? (b - a) : 66) + 6));
        if (ip < -2048) ip = -2048;
        if (ip > 2047)  ip = 2047;
        case ($urandom_range(0, 9))
            0:       fr = 0;
            1:       fr = 1 << (FRAC - 1);     // exact half: rounding tie
            2:       fr = (1 << FRAC) - 1;
            default: fr = $urandom_range(0, (1 << FRAC) - 1);
        endcase
        return {ip[POS_BITS-FRAC-1:0], fr[FRAC-1:0]};
    endfunction

    // Random beat: ~40% loads (col and row each mostly in 0..7, the 8x8 corner the samples hit),
    // the rest samples. Unused fields still carry random content.
    function automatic beat_t random_beat();
        beat_t b;
        b.command = ($urandom_range(0, 99) < 40) ? CMD_LOAD : CMD_SAMPLE;
        b.col     = ($urandom_range(0, 99) < 60) ? LOAD_BITS'($urandom_range(0, 7))
                                                 : LOAD_BITS'($urandom);
        b.row     = ($urandom_range(0, 99) < 60) ? LOAD_BITS'($urandom_range(0, 7))
                                                 : LOAD_BITS'($urandom);
        b.red     = pick_level();
        b.green   = pick_level();
        b.blue    = pick_level();
        b.alpha   = pick_level();
        b.x       = pick_pos(cur_win[REG_MIN_COL], cur_win[REG_MAX_COL]);
        b.y       = pick_pos(cur_win[REG_MIN_ROW], cur_win[REG_MAX_ROW]);
        return b;
    endfunction

    function automatic beat_t load_beat(int col, int row, logic [CH-1:0] r,
                                        logic [CH-1:0] g, logic [CH-1:0] bl,
                                        logic [CH-1:0] al);
        beat_t b;
        b         = '0;
        b.command = CMD_LOAD;
        b.col     = col[LOAD_BITS-1:0];
        b.row     = row[LOAD_BITS-1:0];
        b.red     = r;
        b.green   = g;
        b.blue    = bl;
        b.alpha   = al;
        return b;
    endfunction

    // x, y in Q11.8, given as plain integers (pixel * 256 + fraction)
    function automatic beat_t sample_beat(int x, int y);
        beat_t b;
        b         = '0;
        b.command = CMD_SAMPLE;
        b.x       = x[POS_BITS-1:0];
        b.y       = y[POS_BITS-1:0];
        return b;
    endfunction

    // Offer one beat, with random idle cycles first. Entered and left just
    // after a falling edge; valid is left high so back-to-back beats never
    // drop it.
    task automatic send_beat(input beat_t b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= b.command;
        i_load_col   <= b.col;
        i_load_row   <= b.row;
        i_load_red   <= b.red;
        i_load_green <= b.green;
        i_load_blue  <= b.blue;
        i_load_alpha <= b.alpha;
        i_sample_x   <= b.x;
        i_sample_y   <= b.y;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait for every expected result, then let a trailing load finish.
    task automatic wait_idle();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request so the
    // sampler backs up and drops o_in_ready.
    // ---------------------------------------------------------------------
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: ends the run after too many cycles with no beat on either channel.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin : stimulus
        beat_t b;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_command      = CMD_LOAD;
        i_load_col     = '0;
        i_load_row     = '0;
        i_load_red     = '0;
        i_load_green   = '0;
        i_load_blue    = '0;
        i_load_alpha   = '0;
        i_sample_x     = '0;
        i_sample_y     = '0;
        i_out_ready    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cur_win[REG_MIN_COL] = int'($signed(RST_MIN_COL));
        cur_win[REG_MAX_COL] = int'($signed(RST_MAX_COL));
        cur_win[REG_MIN_ROW] = int'($signed(RST_MIN_ROW));
        cur_win[REG_MAX_ROW] = int'($signed(RST_MAX_ROW));

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the reset window (0..63). The first beat waits out
        // the clearing pass. Corner pixels carry the channel extremes.
        send_beat(load_beat(0, 0, 16'h7FFF, 16'h8000, 16'h0100, 16'hFFFF));
        send_beat(load_beat(1, 0, 16'h8000, 16'h7FFF, 16'h7F00, 16'h0000));
        send_beat(load_beat(0, 1, 16'h1234, 16'hEDCC, 16'h7FFF, 16'h8000));
        send_beat(load_beat(1, 1, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF));
        send_beat(load_beat(63, 63, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_beat(load_beat(62, 63, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_beat(sample_beat(0, 0));                     // whole-pixel hit
        send_beat(sample_beat(128, 128));                 // rounding ties
        send_beat(sample_beat(255, 1));
        send_beat(sample_beat(-524288, -524288));         // most negative position
        send_beat(sample_beat(524287, 524287));           // most positive position
        send_beat(sample_beat(62*256 + 128, 63*256));     // between the two max-row pixels
        send_beat(sample_beat(63*256 + 128, 62*256 + 128)); // upper neighbor clamped
        send_beat(sample_beat(30*256 + 64, 17*256 + 192)); // never loaded: zero
        send_beat(sample_beat(-128, -128));               // below the window edge
        send_beat(load_beat(5, 5, 16'h0064, 16'hFF9C, 16'h00C8, 16'hFF38));
        send_beat(sample_beat(5*256, 5*256));             // read right after write
        send_beat(sample_beat(4*256 + 128, 4*256 + 128));
        send_beat(load_beat(1, 0, 16'h0003, 16'hFFFD, 16'h0001, 16'h7FFF));
        send_beat(sample_beat(128, 0));                   // sees the overwrite

        // Back-pressure: the receiver holds off while samples keep coming, so
        // the result register and the sequencer fill and o_in_ready drops.
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        hold_req = 1'b1;
        @(negedge i_clk);
        repeat (PRESS_BEATS) begin
            b = random_beat();
            b.command = CMD_SAMPLE;
            send_beat(b);
        end

        // Random phases, each with its own window and one of four idle patterns.
        for (int ph = 0; ph < PHASES; ph++) begin
            i_in_valid <= 1'b0;
            wait_idle();
            if (ph == PHASES - 1) begin
                for (int r = 0; r < 4; r++)
                    phase_win[ph][r] = int'($urandom_range(0, 4095)) - 2048;
            end
            write_reg(REG_MIN_COL, phase_win[ph][0]);
            write_reg(REG_MAX_COL, phase_win[ph][1]);
            write_reg(REG_MIN_ROW, phase_win[ph][2]);
            write_reg(REG_MAX_ROW, phase_win[ph][3]);
            cur_win[REG_MIN_COL] = phase_win[ph][0];
            cur_win[REG_MAX_COL] = phase_win[ph][1];
            cur_win[REG_MIN_ROW] = phase_win[ph][2];
            cur_win[REG_MAX_ROW] = phase_win[ph][3];
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            repeat (BEATS_PER) send_beat(random_beat());
        end

        i_in_valid <= 1'b0;
        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/brs_pkg.sv
hdl/brs_ram.sv
hdl/bilinear_rgba_sampler.sv
tb/brs_checker.sv
tb/tb_bilinear_rgba_sampler.sv
